>>> hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

>>> hdl/ncg_pkg.sv
// types and constants of the next combination generator
`default_nettype none

package ncg_pkg;

	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned POS_W      = 4;
	localparam int unsigned LOAD_W     = 8;
	localparam int unsigned INDEX_W    = 4;
	localparam int unsigned SET_SIZE_W = 5;
	localparam int unsigned MAXVAL_W   = 8;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_SIZE  = 1'b0,
		CFG_MAX_VALUE = 1'b1
	} ncg_cfg_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_START   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_LOAD    = 2'd2,
		OP_NOP     = 2'd3
	} ncg_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODES,
		ST_EMIT
	} ncg_state_t;

	// what a cell does to its element when it reaches the head of the row
	typedef enum logic [1:0] {
		MODE_KEEP,
		MODE_INCR,
		MODE_REFILL
	} ncg_mode_t;

	typedef struct packed {
		logic             start;
		logic             capture;
		logic             set_mode;
		logic             shift;
		logic             load;
		logic [POS_W-1:0] load_pos;
		logic             mv_ok;
	} ncg_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/ncg_if.sv
// valid/ready channels of the next combination generator
`default_nettype none

interface ncg_in_if;
	import ncg_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [POS_W-1:0]    position;
	logic [LOAD_W-1:0]   value;

	modport source (output valid, output opcode, output position, output value, input ready);
	modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface ncg_out_if #(
	parameter int unsigned VALUE_BITS = 8
);
	import ncg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] element;
	logic [INDEX_W-1:0]    index;
	logic                  advanced;
	logic                  last;

	modport source (output valid, output element, output index, output advanced, output last,
		input ready);
	modport sink (input valid, input element, input index, input advanced, input last,
		output ready);
endinterface

`default_nettype wire

>>> hdl/ncg_cell.sv
// one position of the combination row
`default_nettype none

module ncg_cell #(
	parameter int unsigned IDX        = 0,
	parameter int unsigned VALUE_BITS = 8,
	parameter int unsigned KW         = 5
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ncg_pkg::ncg_ctrl_t        ctrl,
	input  wire logic [KW-1:0]             k,
	input  wire logic [ncg_pkg::MAXVAL_W-1:0] max_value,
	input  wire logic [ncg_pkg::LOAD_W-1:0]   load_value,
	input  wire logic [VALUE_BITS-1:0]     tail_value,
	input  wire logic [VALUE_BITS-1:0]     right_value,
	input  wire ncg_pkg::ncg_mode_t        right_mode,
	input  wire logic                      right_any,
	input  wire logic                      any_flag,
	output logic [VALUE_BITS-1:0]          value,
	output ncg_pkg::ncg_mode_t             mode,
	output logic                           any_out
);
	import ncg_pkg::*;

	localparam int unsigned SUM_W    = ((VALUE_BITS > MAXVAL_W) ? VALUE_BITS : MAXVAL_W) + 2;
	localparam logic [KW:0] IDX_V    = (KW+1)'(IDX);
	localparam bit          LOADABLE = (IDX < (1 << POS_W));

	logic [VALUE_BITS-1:0] value_q;
	ncg_mode_t             mode_q;
	logic                  flag_q;
	logic                  active;
	logic                  is_tail;
	logic                  load_hit;
	logic [KW:0]           gap;
	logic [SUM_W-1:0]      sum;
	logic                  flag_next;
	ncg_mode_t             mode_next;

	assign active   = {1'b0, k} > IDX_V;
	assign is_tail  = {1'b0, k} == (IDX_V + (KW+1)'(1));
	assign load_hit = LOADABLE && (ctrl.load_pos == POS_W'(IDX));

	// below limit: value + (k-1-i) < max_value
	assign gap       = {1'b0, k} - IDX_V - (KW+1)'(1);
	assign sum       = SUM_W'(value_q) + SUM_W'(gap);
	assign flag_next = active && ctrl.mv_ok && (sum < SUM_W'(max_value));

	always_comb begin
		if (!active) begin
			mode_next = MODE_KEEP;
		end else if (flag_q && !right_any) begin
			mode_next = MODE_INCR;
		end else if (!flag_q && !right_any && any_flag) begin
			mode_next = MODE_REFILL;
		end else begin
			mode_next = MODE_KEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			mode_q  <= MODE_KEEP;
			flag_q  <= 1'b0;
		end else begin
			priority if (ctrl.start) begin
				if (active) begin
					value_q <= VALUE_BITS'(IDX);
				end
				mode_q <= MODE_KEEP;
			end else if (ctrl.load && load_hit) begin
				value_q <= VALUE_BITS'(load_value);
			end else if (ctrl.capture) begin
				flag_q <= flag_next;
			end else if (ctrl.set_mode) begin
				mode_q <= mode_next;
			end else if (ctrl.shift && active) begin
				value_q <= is_tail ? tail_value : right_value;
				mode_q  <= is_tail ? MODE_KEEP : right_mode;
			end
		end
	end

	assign value   = value_q;
	assign mode    = mode_q;
	assign any_out = flag_q || right_any;

endmodule

`default_nettype wire

>>> hdl/next_combination_generator.sv
// top level of the next combination generator
`default_nettype none
`include "assert_macros.svh"

// Steps a k-element combination to its lexicographic successor. The elements
// live in a row of cells; each start or advance rotates the first k cells
// through the head of the row, one element per cycle unless the output
// register stalls, and every element is fixed up there (incremented at the
// pivot, refilled after it) on its way to the output register. A start goes
// straight to the rotation; an advance first captures the per-cell limit
// flags, then marks the pivot, then rotates. A load produces no item. The
// single head port of the row sets this rate. A new item is taken as soon as
// the last element has moved into the output register.
module next_combination_generator #(
	parameter int unsigned MAX_SET_SIZE = 16,
	parameter int unsigned VALUE_BITS   = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ncg_in_if.sink                             in_ch,
	ncg_out_if.source                          out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [ncg_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [ncg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ncg_pkg::*;

	localparam int unsigned KW = $clog2(MAX_SET_SIZE + 1);

	logic [SET_SIZE_W-1:0] set_size_q;
	logic [MAXVAL_W-1:0]   max_value_q;
	logic [KW-1:0]         k;
	logic                  k_zero;

	ncg_state_t state_q;
	ncg_state_t state_d;
	ncg_ctrl_t  ctrl;
	ncg_op_t    op;
	logic       in_fire;
	logic       emit_step;
	logic       emit_done;

	logic [KW-1:0]         e_q;
	logic                  ok_q;
	logic [VALUE_BITS-1:0] prev_q;
	logic [VALUE_BITS-1:0] head_next;

	logic                  ov_q;
	logic [VALUE_BITS-1:0] element_q;
	logic [INDEX_W-1:0]    index_q;
	logic                  advanced_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] cell_value [MAX_SET_SIZE];
	ncg_mode_t             cell_mode  [MAX_SET_SIZE];
	logic                  cell_any   [MAX_SET_SIZE];
	logic [VALUE_BITS-1:0] right_value [MAX_SET_SIZE];
	ncg_mode_t             right_mode  [MAX_SET_SIZE];
	logic                  right_any   [MAX_SET_SIZE];
	logic [MAX_SET_SIZE-1:0] incr_vec;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q  <= SET_SIZE_W'(1);
			max_value_q <= '1;
		end else if (cfg_we) begin
			unique case (ncg_cfg_t'(cfg_idx))
				CFG_SET_SIZE:  set_size_q  <= SET_SIZE_W'(cfg_data);
				CFG_MAX_VALUE: max_value_q <= MAXVAL_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(set_size_q) > MAX_SET_SIZE) begin
			k = KW'(MAX_SET_SIZE);
		end else begin
			k = KW'(set_size_q);
		end
	end

	assign k_zero = (k == '0);
	assign op     = ncg_op_t'(in_ch.opcode);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign emit_step = (state_q == ST_EMIT) && (!ov_q || out_ch.ready);
	assign emit_done = emit_step && (e_q == (k - KW'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && !k_zero) begin
					if (op == OP_START) begin
						state_d = ST_EMIT;
					end else if (op == OP_ADVANCE) begin
						state_d = ST_MODES;
					end
				end
			end
			ST_MODES: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctrl          = '0;
		ctrl.load_pos = in_ch.position;
		ctrl.mv_ok    = 32'(max_value_q) >= 32'(k);
		in_ch.ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready  = 1'b1;
				ctrl.start   = in_fire && !k_zero && (op == OP_START);
				ctrl.capture = in_fire && !k_zero && (op == OP_ADVANCE);
				ctrl.load    = in_fire && (op == OP_LOAD);
			end
			ST_MODES: ctrl.set_mode = 1'b1;
			ST_EMIT:  ctrl.shift    = emit_step;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// head of the row
	always_comb begin
		unique case (cell_mode[0])
			MODE_KEEP:   head_next = cell_value[0];
			MODE_INCR:   head_next = cell_value[0] + VALUE_BITS'(1);
			MODE_REFILL: head_next = prev_q + VALUE_BITS'(1);
			default:     head_next = cell_value[0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q  <= '0;
			ok_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				e_q <= '0;
			end else if (emit_step) begin
				e_q <= e_q + KW'(1);
			end
			if (ctrl.start) begin
				ok_q <= 1'b1;
			end else if (ctrl.set_mode) begin
				ok_q <= cell_any[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			prev_q <= head_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_step) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			element_q  <= head_next;
			index_q    <= INDEX_W'(e_q);
			advanced_q <= ok_q;
			last_q     <= (e_q == (k - KW'(1)));
		end
	end

	assign out_ch.valid    = ov_q;
	assign out_ch.element  = element_q;
	assign out_ch.index    = index_q;
	assign out_ch.advanced = advanced_q;
	assign out_ch.last     = last_q;

	// row of cells
	for (genvar g = 0; g < MAX_SET_SIZE; g++) begin : g_row
		if (g == MAX_SET_SIZE - 1) begin : g_end
			assign right_value[g] = head_next;
			assign right_mode[g]  = MODE_KEEP;
			assign right_any[g]   = 1'b0;
		end else begin : g_mid
			assign right_value[g] = cell_value[g+1];
			assign right_mode[g]  = cell_mode[g+1];
			assign right_any[g]   = cell_any[g+1];
		end

		ncg_cell #(
			.IDX        (g),
			.VALUE_BITS (VALUE_BITS),
			.KW         (KW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.k           (k),
			.max_value   (max_value_q),
			.load_value  (in_ch.value),
			.tail_value  (head_next),
			.right_value (right_value[g]),
			.right_mode  (right_mode[g]),
			.right_any   (right_any[g]),
			.any_flag    (cell_any[0]),
			.value       (cell_value[g]),
			.mode        (cell_mode[g]),
			.any_out     (cell_any[g])
		);

		assign incr_vec[g] = (cell_mode[g] == MODE_INCR);
	end

	`ASSERT_ALWAYS(a_one_pivot, $onehot0(incr_vec), "more than one cell marked as pivot")
	`ASSERT_NEXT(a_modes_to_emit, state_q == ST_MODES, state_q == ST_EMIT,
		"pivot marking not followed by emission")
	`ASSERT_IMPL(a_item_from_emit, $rose(ov_q), $past(state_q) == ST_EMIT,
		"output item appeared outside emission")

endmodule

`default_nettype wire

>>> verif/next_combination_generator_tb.sv
// testbench of the next combination generator: directed and random steps against a predictor
`default_nettype none

module next_combination_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ncg_pkg::*;

	localparam int unsigned SLOTS      = 16;
	localparam int unsigned QUIET_MAX  = 4000;
	localparam int unsigned IDLE_PCT   = 37;
	localparam int unsigned DRAIN_WAIT = 40;

	typedef struct {
		logic [7:0]         element;
		logic [INDEX_W-1:0] index;
		logic               advanced;
		logic               last;
	} element_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ncg_in_if in_ch();
	ncg_out_if #(.VALUE_BITS(8)) out_ch();

	next_combination_generator #(
		.MAX_SET_SIZE(SLOTS),
		.VALUE_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	logic [7:0]            comb [SLOTS] = '{default: '0};
	logic [SET_SIZE_W-1:0] set_size = 5'd1;
	logic [MAXVAL_W-1:0]   max_value = 8'd255;
	element_t              pending_elements [$];
	int unsigned           mismatches = 0;
	int unsigned           quiet_cycles = 0;
	bit                    calm = 1'b0;

	always #5 clk = ~clk;

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic step_forward(int unsigned k);
		int lim;
		if (k == 0 || int'(max_value) < int'(k))
			return 1'b0;
		for (int n = k; n > 0; n--) begin
			lim = int'(max_value) - (int'(k) - n);
			if (int'(comb[n-1]) < lim) begin
				comb[n-1] = comb[n-1] + 8'd1;
				for (int j = n; j < k; j++)
					comb[j] = comb[j-1] + 8'd1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void predict_item(ncg_op_t op, logic [POS_W-1:0] pos, logic [7:0] val);
		int unsigned k;
		logic ok;
		element_t e;
		k = (set_size > SLOTS) ? SLOTS : set_size;
		ok = 1'b0;
		case (op)
			OP_START: begin
				for (int i = 0; i < k; i++)
					comb[i] = i[7:0];
				ok = 1'b1;
			end
			OP_ADVANCE: ok = step_forward(k);
			OP_LOAD: comb[pos] = val;
			default: ;
		endcase
		if (op == OP_START || op == OP_ADVANCE) begin
			for (int i = 0; i < k; i++) begin
				e.element  = comb[i];
				e.index    = i[INDEX_W-1:0];
				e.advanced = ok;
				e.last     = (i == k - 1);
				pending_elements.push_back(e);
			end
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && cfg_we) begin
			case (ncg_cfg_t'(cfg_idx))
				CFG_SET_SIZE: set_size = cfg_data[SET_SIZE_W-1:0];
				CFG_MAX_VALUE: max_value = cfg_data[MAXVAL_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && in_ch.valid && in_ch.ready)
			predict_item(ncg_op_t'(in_ch.opcode), in_ch.position, in_ch.value);
	end

	always @(posedge clk) begin
		element_t exp_e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_elements.size() == 0) begin
				report_mismatch($sformatf("unexpected item element %0d index %0d",
					out_ch.element, out_ch.index));
			end else begin
				exp_e = pending_elements.pop_front();
				if (out_ch.element !== exp_e.element)
					report_mismatch($sformatf("element %0d, want %0d at index %0d",
						out_ch.element, exp_e.element, exp_e.index));
				if (out_ch.index !== exp_e.index)
					report_mismatch($sformatf("index %0d, want %0d", out_ch.index, exp_e.index));
				if (out_ch.advanced !== exp_e.advanced)
					report_mismatch($sformatf("advanced %0b, want %0b at index %0d",
						out_ch.advanced, exp_e.advanced, exp_e.index));
				if (out_ch.last !== exp_e.last)
					report_mismatch($sformatf("last %0b, want %0b at index %0d",
						out_ch.last, exp_e.last, exp_e.index));
			end
		end
	end

	always @(negedge clk)
		out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_item(ncg_op_t op, logic [POS_W-1:0] pos, logic [7:0] val);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid    <= 1'b1;
		in_ch.opcode   <= op;
		in_ch.position <= pos;
		in_ch.value    <= val;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_elements.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic configure(int unsigned k, int unsigned maxv);
		wait_idle();
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= CFG_SET_SIZE;
		cfg_data <= k[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_idx  <= CFG_MAX_VALUE;
		cfg_data <= maxv[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_start_and_advance();
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		send_item(OP_START, 4'd0, 8'd0);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		configure(16, 255);
		send_item(OP_START, 4'd0, 8'd0);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
	endtask

	task automatic test_final_combination();
		configure(3, 4);
		send_item(OP_LOAD, 4'd0, 8'd2);
		send_item(OP_LOAD, 4'd1, 8'd3);
		send_item(OP_LOAD, 4'd2, 8'd4);
		send_item(OP_LOAD, 4'd9, 8'd77);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		send_item(OP_START, 4'd0, 8'd0);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		configure(5, 3);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		configure(1, 0);
		send_item(OP_START, 4'd0, 8'd0);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
	endtask

	task automatic test_degenerate_sizes();
		configure(0, 255);
		send_item(OP_START, 4'd0, 8'd0);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		configure(31, 255);
		send_item(OP_START, 4'd0, 8'd0);
		send_item(OP_LOAD, 4'd15, 8'd255);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
		send_item(OP_NOP, 4'd15, 8'd255);
		send_item(OP_ADVANCE, 4'd0, 8'd0);
	endtask

	task automatic test_random_walks(int unsigned phases, int unsigned per_phase);
		int unsigned k;
		int unsigned maxv;
		int unsigned r;
		for (int p = 0; p < phases; p++) begin
			case (p % 6)
				0: begin
					k = $urandom_range(1, 4);
					maxv = k + $urandom_range(0, 3);
				end
				1: begin
					k = 16;
					maxv = $urandom_range(15, 18);
				end
				2: begin
					k = $urandom_range(17, 31);
					maxv = $urandom_range(14, 18);
				end
				3: begin
					k = $urandom_range(2, 8);
					maxv = $urandom_range(0, 255);
				end
				4: begin
					k = $urandom_range(1, 5);
					maxv = $urandom_range(0, k + 2);
				end
				default: begin
					k = $urandom_range(0, 31);
					maxv = $urandom_range(0, 255);
				end
			endcase
			configure(k, maxv);
			calm = (p % 6 == 4);
			send_item(OP_START, 4'($urandom), 8'($urandom));
			for (int n = 1; n < per_phase; n++) begin
				r = $urandom_range(99);
				if (r < 72)
					send_item(OP_ADVANCE, 4'($urandom), 8'($urandom));
				else if (r < 84)
					send_item(OP_LOAD, 4'($urandom), 8'($urandom));
				else if (r < 93)
					send_item(OP_START, 4'($urandom), 8'($urandom));
				else
					send_item(OP_NOP, 4'($urandom), 8'($urandom));
			end
			calm = 1'b0;
		end
	endtask

	initial begin
		in_ch.valid    = 1'b0;
		in_ch.opcode   = OP_START;
		in_ch.position = '0;
		in_ch.value    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_start_and_advance();
		test_final_combination();
		test_degenerate_sizes();
		test_random_walks(6, 56);

		wait_idle();
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

>>> next_combination_generator.f
+incdir+hdl
hdl/ncg_pkg.sv
hdl/ncg_if.sv
hdl/ncg_cell.sv
hdl/next_combination_generator.sv
verif/next_combination_generator_tb.sv
